// File: src/usde_pkg.sv
// ----------------------------------------------------------------------------
// usde_pkg
// Types, constants and helper functions shared by the display escaper blocks.
// ----------------------------------------------------------------------------
package usde_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       out_last;
	} out_t;

	// one byte to be written out, either copied or escaped
	typedef struct packed {
		logic [7:0] data;
		logic       raw;
		logic       last;
	} act_t;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] BACKSLASH = 8'h5C;
	localparam logic [7:0] LOWER_X   = 8'h78;
	localparam logic [7:0] PRINT_LO  = 8'h20;
	localparam logic [7:0] PRINT_HI  = 8'h7E;
	localparam logic [7:0] LEAD2_LO  = 8'hC2;
	localparam logic [7:0] LEAD2_HI  = 8'hDF;
	localparam logic [7:0] LEAD3_LO  = 8'hE0;
	localparam logic [7:0] LEAD3_HI  = 8'hEF;
	localparam logic [7:0] LEAD4_LO  = 8'hF0;
	localparam logic [7:0] LEAD4_HI  = 8'hF4;
	localparam logic [7:0] CONT_MASK = 8'hC0;
	localparam logic [7:0] CONT_TAG  = 8'h80;

	localparam logic [20:0] CODE_MIN3  = 21'h000800;
	localparam logic [20:0] CODE_MIN4  = 21'h010000;
	localparam logic [20:0] CODE_MAX   = 21'h10FFFF;
	localparam logic [20:0] SURR_LO    = 21'h00D800;
	localparam logic [20:0] SURR_HI    = 21'h00DFFF;

	localparam logic [7:0] HEX_DIGITS [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
	};

	function automatic logic [2:0] lead_length(input logic [7:0] b);
		logic [2:0] len;
		if (b >= LEAD2_LO && b <= LEAD2_HI) begin
			len = 3'd2;
		end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
			len = 3'd3;
		end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
			len = 3'd4;
		end else begin
			len = 3'd0;
		end
		return len;
	endfunction

	function automatic logic is_plain(input logic [7:0] b);
		return (b >= PRINT_LO) && (b <= PRINT_HI) && (b != BACKSLASH);
	endfunction

	function automatic logic is_invisible(input logic [20:0] c);
		return (c >= 21'h80 && c <= 21'h9F) || c == 21'hAD ||
			(c >= 21'h200B && c <= 21'h200F) || c == 21'h2028 || c == 21'h2029 ||
			(c >= 21'h202A && c <= 21'h202E) || (c >= 21'h2060 && c <= 21'h2064) ||
			(c >= 21'h2066 && c <= 21'h206F) || c == 21'hFEFF;
	endfunction

	function automatic logic seq_ok(
		input logic [7:0] p0,
		input logic [7:0] p1,
		input logic [7:0] p2,
		input logic [7:0] b,
		input logic [2:0] len
	);
		logic [20:0] code;
		logic        ok;
		case (len)
			3'd2: code = {10'd0, p0[4:0], b[5:0]};
			3'd3: code = {5'd0, p0[3:0], p1[5:0], b[5:0]};
			default: code = {p0[2:0], p1[5:0], p2[5:0], b[5:0]};
		endcase
		ok = 1'b1;
		if (len == 3'd3 && code < CODE_MIN3) ok = 1'b0;
		if (len == 3'd4 && code < CODE_MIN4) ok = 1'b0;
		if (code >= SURR_LO && code <= SURR_HI) ok = 1'b0;
		if (code > CODE_MAX) ok = 1'b0;
		if (is_invisible(code)) ok = 1'b0;
		return ok;
	endfunction

	// index of the final output char for one byte
	function automatic logic [1:0] last_phase(input act_t a);
		logic [1:0] ph;
		if (a.raw || is_plain(a.data)) begin
			ph = 2'd0;
		end else if (a.data == BACKSLASH) begin
			ph = 2'd1;
		end else begin
			ph = 2'd3;
		end
		return ph;
	endfunction

	function automatic logic [7:0] out_byte(input act_t a, input logic [1:0] ph);
		logic [7:0] c;
		if (a.raw || is_plain(a.data)) begin
			c = a.data;
		end else if (a.data == BACKSLASH) begin
			c = BACKSLASH;
		end else begin
			case (ph)
				2'd0: c = BACKSLASH;
				2'd1: c = LOWER_X;
				2'd2: c = HEX_DIGITS[a.data[7:4]];
				default: c = HEX_DIGITS[a.data[3:0]];
			endcase
		end
		return c;
	endfunction

endpackage

// File: src/usde_front.sv
// ----------------------------------------------------------------------------
// usde_front
// Accepts path bytes, tracks held UTF-8 bytes and queues per-byte actions.
// ----------------------------------------------------------------------------
module usde_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  usde_pkg::in_t  in_data,
	output logic           act_valid,
	input  logic           act_ready,
	output usde_pkg::act_t act_data
);
	import usde_pkg::*;

	logic [7:0] pend_q [3];
	logic [1:0] pc_q;
	logic [2:0] el_q;

	logic [7:0] list_q [4];
	logic [2:0] act_n_q;
	logic [2:0] act_i_q;
	logic       raw_q;
	logic       last_q;

	logic [7:0] b;
	logic       is_cont;
	logic [2:0] blen;
	logic       take_b;
	logic       store0;
	logic       store_pc;
	logic       raw;
	logic [1:0] flush_n;
	logic [2:0] n;
	logic [7:0] list [4];
	logic       accept;

	assign b        = in_data.in_byte;
	assign is_cont  = (b & CONT_MASK) == CONT_TAG;
	assign blen     = lead_length(b);
	assign in_ready = act_i_q == act_n_q;
	assign accept   = in_valid && in_ready;

	always_comb begin
		take_b   = 1'b0;
		store0   = 1'b0;
		store_pc = 1'b0;
		raw      = 1'b0;
		flush_n  = 2'd0;
		if (pc_q == 2'd0) begin
			if (blen != 3'd0 && !in_data.in_last) store0 = 1'b1;
			else take_b = 1'b1;
		end else if (!is_cont) begin
			flush_n = pc_q;
			if (blen != 3'd0 && !in_data.in_last) store0 = 1'b1;
			else take_b = 1'b1;
		end else if (({1'b0, pc_q} + 3'd1) >= el_q) begin
			flush_n = pc_q;
			take_b  = 1'b1;
			raw     = seq_ok(pend_q[0], pend_q[1], pend_q[2], b, el_q);
		end else if (in_data.in_last) begin
			flush_n = pc_q;
			take_b  = 1'b1;
		end else begin
			store_pc = 1'b1;
		end
		n = {1'b0, flush_n} + {2'd0, take_b};
		for (int k = 0; k < 3; k++) begin
			list[k] = (k < int'(pc_q)) ? pend_q[k] : b;
		end
		list[3] = b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= 2'd0;
			el_q    <= 3'd0;
			act_n_q <= 3'd0;
			act_i_q <= 3'd0;
		end else begin
			if (accept) begin
				act_n_q <= n;
				act_i_q <= 3'd0;
				raw_q   <= raw;
				last_q  <= in_data.in_last;
				for (int k = 0; k < 4; k++) begin
					list_q[k] <= list[k];
				end
				if (store0) begin
					pend_q[0] <= b;
					pc_q      <= 2'd1;
					el_q      <= blen;
				end else if (store_pc) begin
					pend_q[pc_q] <= b;
					pc_q         <= pc_q + 2'd1;
				end else begin
					pc_q <= 2'd0;
					el_q <= 3'd0;
				end
			end else if (act_valid && act_ready) begin
				act_i_q <= act_i_q + 3'd1;
			end
		end
	end

	assign act_valid     = act_i_q != act_n_q;
	assign act_data.data = list_q[act_i_q[1:0]];
	assign act_data.raw  = raw_q;
	assign act_data.last = last_q && ((act_i_q + 3'd1) == act_n_q);

endmodule

// File: src/usde_queue.sv
// ----------------------------------------------------------------------------
// usde_queue
// Short action queue between the front and the back.
// ----------------------------------------------------------------------------
module usde_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  usde_pkg::act_t wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output usde_pkg::act_t rd_data
);
	import usde_pkg::*;

	act_t              mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wp_q;
	logic [QUEUE_AW-1:0] rp_q;
	logic [QUEUE_AW:0]   cnt_q;
	logic              push;
	logic              pop;

	assign wr_ready = cnt_q != (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: src/usde_back.sv
// ----------------------------------------------------------------------------
// usde_back
// Expands each queued action into one to four output chars.
// ----------------------------------------------------------------------------
module usde_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           act_valid,
	output logic           act_ready,
	input  usde_pkg::act_t act_data,
	output logic           out_valid,
	input  logic           out_ready,
	output usde_pkg::out_t out_data
);
	import usde_pkg::*;

	act_t       cur_q;
	logic       busy_q;
	logic [1:0] ph_q;
	logic       ov_q;
	out_t       od_q;

	logic       adv;
	logic       fin;
	logic       take;

	assign adv       = !ov_q || out_ready;
	assign fin       = busy_q && (ph_q == last_phase(cur_q));
	assign act_ready = !busy_q || (adv && fin);
	assign take      = act_valid && act_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= 2'd0;
			ov_q   <= 1'b0;
		end else begin
			if (adv) begin
				ov_q <= busy_q;
				if (busy_q) begin
					od_q.out_char <= out_byte(cur_q, ph_q);
					od_q.out_last <= cur_q.last && fin;
				end
			end
			if (take) begin
				cur_q  <= act_data;
				busy_q <= 1'b1;
				ph_q   <= 2'd0;
			end else if (adv && busy_q) begin
				if (fin) busy_q <= 1'b0;
				else ph_q <= ph_q + 2'd1;
			end
		end
	end

	assign out_valid = ov_q;
	assign out_data  = od_q;

endmodule

// File: src/utf8_safe_display_escaper.sv
// ----------------------------------------------------------------------------
// utf8_safe_display_escaper
// Turns raw path bytes into displayable text: valid visible UTF-8 sequences
// pass through, everything else is escaped as \\ or \xHH.
//
//   channel | ports                          | payload
//   --------+--------------------------------+---------------------------
//   input   | in_valid, in_ready, in_data    | in_byte, in_last
//   output  | out_valid, out_ready, out_data | out_char, out_last
//
// an input byte is accepted only once every action released by the previous
// byte has entered the action queue; output runs at one char per cycle while
// out_ready is high and actions are queued; \xHH is four chars, \\ two, a copy one
// held bytes are released only when a sequence is judged, so a byte may
// release up to four queued actions (sixteen chars)
// reset clears the held count, the queue and the output register
// either side may stall independently through the four-entry queue
// ----------------------------------------------------------------------------
module utf8_safe_display_escaper (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  usde_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output usde_pkg::out_t out_data
);
	import usde_pkg::*;

	logic fa_valid;
	logic fa_ready;
	act_t fa_data;
	logic qb_valid;
	logic qb_ready;
	act_t qb_data;

	usde_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.act_valid (fa_valid),
		.act_ready (fa_ready),
		.act_data  (fa_data)
	);

	usde_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fa_valid),
		.wr_ready (fa_ready),
		.wr_data  (fa_data),
		.rd_valid (qb_valid),
		.rd_ready (qb_ready),
		.rd_data  (qb_data)
	);

	usde_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.act_valid (qb_valid),
		.act_ready (qb_ready),
		.act_data  (qb_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
